@@ rtl/cfp_pkg.sv @@
package cfp_pkg;

  localparam int HEADER_BYTES = 5;
  localparam int CHECK_BYTES  = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE_1 = 2'd1;

  localparam logic [7:0] SYNC_BYTE_0_RST = 8'd66;
  localparam logic [7:0] SYNC_BYTE_1_RST = 8'd70;

  localparam int POS_SYNC_0 = 0;
  localparam int POS_SYNC_1 = 1;
  localparam int POS_MSG_ID = 2;
  localparam int POS_LEN_LO = 3;
  localparam int POS_LEN_HI = 4;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_PAYLOAD    = 3'd1,
    EV_ACCEPT     = 3'd2,
    EV_LEN_TOO_BIG = 3'd3,
    EV_CHK_A_BAD  = 3'd4,
    EV_CHK_B_BAD  = 3'd5
  } event_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  data_byte;
    logic [11:0] payload_index;
    logic [7:0]  msg_id;
    logic [11:0] payload_len;
  } cfp_result_t;

endpackage

@@ rtl/cfp_core.sv @@
module cfp_core
  import cfp_pkg::*;
#(
  parameter int FRAME_BUFFER_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  output cfp_result_t           result
);

  localparam int POS_W = $clog2(FRAME_BUFFER_BYTES);
  localparam int LEN_W = $clog2(FRAME_BUFFER_BYTES - HEADER_BYTES - 1);
  localparam logic [16:0] PAYLOAD_LIMIT =
    17'(FRAME_BUFFER_BYTES - HEADER_BYTES - CHECK_BYTES);

  logic [7:0]       sync_byte_0_r, sync_byte_1_r;
  logic [POS_W-1:0] position_r, position_nxt;
  logic [7:0]       length_low_r, length_low_nxt;
  logic [LEN_W-1:0] frame_length_r, frame_length_nxt;
  logic [7:0]       sum_a_r, sum_a_nxt;
  logic [7:0]       sum_b_r, sum_b_nxt;
  logic [7:0]       frame_id_r, frame_id_nxt;

  logic [7:0]        add_a, add_b;
  logic [POS_W-1:0]  frame_end, idx_w, len_pos;
  logic [POS_W+11:0] idx_ext, len_ext;
  logic [15:0]       len_full;
  logic              clear;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_0_r <= SYNC_BYTE_0_RST;
      sync_byte_1_r <= SYNC_BYTE_1_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_SYNC_BYTE_0) begin
        sync_byte_0_r <= cfg_wdata;
      end else if (cfg_index == REG_SYNC_BYTE_1) begin
        sync_byte_1_r <= cfg_wdata;
      end
    end
  end

  assign add_a     = sum_a_r + rx_byte;
  assign add_b     = sum_b_r + add_a;
  assign len_pos   = POS_W'(frame_length_r);
  assign frame_end = len_pos + POS_W'(HEADER_BYTES);
  assign idx_w     = position_r - POS_W'(HEADER_BYTES);
  assign idx_ext   = {12'd0, idx_w};
  assign len_ext   = {12'd0, len_pos};
  assign len_full  = {rx_byte, length_low_r};

  always_comb begin
    position_nxt     = position_r;
    length_low_nxt   = length_low_r;
    frame_length_nxt = frame_length_r;
    sum_a_nxt        = sum_a_r;
    sum_b_nxt        = sum_b_r;
    frame_id_nxt     = frame_id_r;
    clear            = 1'b0;
    result           = '0;
    result.event_res = EV_NONE;

    priority if (position_r == POS_W'(POS_SYNC_0)) begin
      if (rx_byte == sync_byte_0_r) begin
        sum_a_nxt    = add_a;
        sum_b_nxt    = add_b;
        position_nxt = POS_W'(POS_SYNC_1);
      end
    end else if (position_r == POS_W'(POS_SYNC_1)) begin
      if (rx_byte == sync_byte_1_r) begin
        sum_a_nxt    = add_a;
        sum_b_nxt    = add_b;
        position_nxt = POS_W'(POS_MSG_ID);
      end
    end else if (position_r == POS_W'(POS_MSG_ID)) begin
      frame_id_nxt = rx_byte;
      sum_a_nxt    = add_a;
      sum_b_nxt    = add_b;
      position_nxt = POS_W'(POS_LEN_LO);
    end else if (position_r == POS_W'(POS_LEN_LO)) begin
      length_low_nxt = rx_byte;
      sum_a_nxt      = add_a;
      sum_b_nxt      = add_b;
      position_nxt   = POS_W'(POS_LEN_HI);
    end else if (position_r == POS_W'(POS_LEN_HI)) begin
      if ({1'b0, len_full} > PAYLOAD_LIMIT) begin
        result.event_res = EV_LEN_TOO_BIG;
        clear            = 1'b1;
      end else begin
        frame_length_nxt = len_full[LEN_W-1:0];
        sum_a_nxt        = add_a;
        sum_b_nxt        = add_b;
        position_nxt     = POS_W'(HEADER_BYTES);
      end
    end else if (position_r < frame_end) begin
      result.event_res     = EV_PAYLOAD;
      result.data_byte     = rx_byte;
      result.payload_index = idx_ext[11:0];
      result.msg_id        = frame_id_r;
      result.payload_len   = len_ext[11:0];
      sum_a_nxt            = add_a;
      sum_b_nxt            = add_b;
      position_nxt         = position_r + 1'b1;
    end else if (position_r == frame_end) begin
      if (rx_byte == sum_a_r) begin
        position_nxt = position_r + 1'b1;
      end else begin
        result.event_res   = EV_CHK_A_BAD;
        result.msg_id      = frame_id_r;
        result.payload_len = len_ext[11:0];
        clear              = 1'b1;
      end
    end else if (position_r == frame_end + 1'b1) begin
      result.event_res   = (rx_byte == sum_b_r) ? EV_ACCEPT : EV_CHK_B_BAD;
      result.msg_id      = frame_id_r;
      result.payload_len = len_ext[11:0];
      clear              = 1'b1;
    end else begin
      clear = 1'b1;
    end

    if (clear) begin
      position_nxt     = '0;
      length_low_nxt   = '0;
      frame_length_nxt = '0;
      sum_a_nxt        = '0;
      sum_b_nxt        = '0;
      frame_id_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r     <= '0;
      length_low_r   <= '0;
      frame_length_r <= '0;
      sum_a_r        <= '0;
      sum_b_r        <= '0;
      frame_id_r     <= '0;
    end else if (step) begin
      position_r     <= position_nxt;
      length_low_r   <= length_low_nxt;
      frame_length_r <= frame_length_nxt;
      sum_a_r        <= sum_a_nxt;
      sum_b_r        <= sum_b_nxt;
      frame_id_r     <= frame_id_nxt;
    end
  end

endmodule

@@ rtl/cfp_out_buf.sv @@
module cfp_out_buf
  import cfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  cfp_result_t push_data,
  output logic        push_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output cfp_result_t out_data
);

  logic        main_valid_r, skid_valid_r;
  cfp_result_t main_r, skid_r;
  logic        pop;

  assign pop        = main_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_data   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || pop) begin
      main_valid_r <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || pop) begin
      main_r <= skid_valid_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

@@ rtl/checksummed_frame_parser_top.sv @@
// Each result beat is registered into the output buffer (main entry, or skid entry while main waits) for out_valid.
// Throughput: one byte per cycle while in_ready is high; the running sums and position counter update in one pass.
// A two-entry output buffer keeps in_ready high while one result waits on out_ready.
// Reset (synchronous, rst_n low) clears the frame state and output buffer and
// restores the sync bytes to 66 and 70.
module checksummed_frame_parser_top
  import cfp_pkg::*;
#(
  parameter int FRAME_BUFFER_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_event_res,
  output logic [7:0]            out_data_byte,
  output logic [11:0]           out_payload_index,
  output logic [7:0]            out_msg_id,
  output logic [11:0]           out_payload_len
);

  cfp_result_t step_result, out_result;
  logic        step;

  assign step = in_valid && in_ready;

  cfp_core #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .rx_byte   (in_rx_byte),
    .result    (step_result)
  );

  cfp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .push_data  (step_result),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_result)
  );

  assign out_event_res     = out_result.event_res;
  assign out_data_byte     = out_result.data_byte;
  assign out_payload_index = out_result.payload_index;
  assign out_msg_id        = out_result.msg_id;
  assign out_payload_len   = out_result.payload_len;

endmodule

@@ rtl/cfp_checker.sv @@
module cfp_checker
  import cfp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic [2:0]  out_event_res,
  input logic [7:0]  out_data_byte,
  input logic [11:0] out_payload_index,
  input logic [7:0]  out_msg_id,
  input logic [11:0] out_payload_len
);

  a_stall_implies_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result beat pending");

  a_beat_produces_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat did not produce a result");

  a_event_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_res <= EV_CHK_B_BAD)
    else $error("undefined event code");

  a_payload_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != EV_PAYLOAD |->
      out_data_byte == 8'd0 && out_payload_index == 12'd0)
    else $error("payload fields set on non-payload event");

  a_frame_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_NONE || out_event_res == EV_LEN_TOO_BIG) |->
      out_msg_id == 8'd0 && out_payload_len == 12'd0)
    else $error("frame fields set outside a frame");

endmodule

bind checksummed_frame_parser_top cfp_checker u_cfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_event_res     (out_event_res),
  .out_data_byte     (out_data_byte),
  .out_payload_index (out_payload_index),
  .out_msg_id        (out_msg_id),
  .out_payload_len   (out_payload_len)
);

@@ tb/frame_event_checker.sv @@
`timescale 1ns / 1ps

module frame_event_checker
  import cfp_pkg::*;
#(
  parameter int FRAME_BUFFER_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [2:0]            out_event_res,
  input  logic [7:0]            out_data_byte,
  input  logic [11:0]           out_payload_index,
  input  logic [7:0]            out_msg_id,
  input  logic [11:0]           out_payload_len,
  output int                    mismatches,
  output int                    events_pending
);

  localparam int PAYLOAD_MAX = FRAME_BUFFER_BYTES - HEADER_BYTES - CHECK_BYTES;

  logic [7:0]  sync0;
  logic [7:0]  sync1;
  logic [11:0] pos;
  logic [7:0]  len_lo;
  logic [15:0] frame_len;
  logic [7:0]  run_a;
  logic [7:0]  run_b;
  logic [7:0]  frame_id;

  cfp_result_t expected_events[$];
  cfp_result_t want;

  function automatic void drop_frame();
    pos       = '0;
    len_lo    = '0;
    frame_len = '0;
    run_a     = '0;
    run_b     = '0;
    frame_id  = '0;
  endfunction

  function automatic void fold_byte(input logic [7:0] b);
    run_a = run_a + b;
    run_b = run_b + run_a;
  endfunction

  function automatic cfp_result_t parse_byte(input logic [7:0] b);
    cfp_result_t r;
    logic [15:0] req_len;
    int          frame_end;
    r           = '0;
    r.event_res = EV_NONE;
    frame_end   = int'(frame_len) + HEADER_BYTES;
    if (pos == POS_SYNC_0) begin
      if (b == sync0) begin
        fold_byte(b);
        pos = 12'(POS_SYNC_1);
      end
    end else if (pos == POS_SYNC_1) begin
      if (b == sync1) begin
        fold_byte(b);
        pos = 12'(POS_MSG_ID);
      end
    end else if (pos == POS_MSG_ID) begin
      frame_id = b;
      fold_byte(b);
      pos = 12'(POS_LEN_LO);
    end else if (pos == POS_LEN_LO) begin
      len_lo = b;
      fold_byte(b);
      pos = 12'(POS_LEN_HI);
    end else if (pos == POS_LEN_HI) begin
      req_len = {b, len_lo};
      if (req_len > PAYLOAD_MAX) begin
        r.event_res = EV_LEN_TOO_BIG;
        drop_frame();
      end else begin
        frame_len = req_len;
        fold_byte(b);
        pos = 12'(HEADER_BYTES);
      end
    end else if (int'(pos) < frame_end) begin
      r.event_res     = EV_PAYLOAD;
      r.data_byte     = b;
      r.payload_index = pos - 12'(HEADER_BYTES);
      r.msg_id        = frame_id;
      r.payload_len   = frame_len[11:0];
      fold_byte(b);
      pos = pos + 1'b1;
    end else if (int'(pos) == frame_end) begin
      if (b == run_a) begin
        pos = pos + 1'b1;
      end else begin
        r.event_res   = EV_CHK_A_BAD;
        r.msg_id      = frame_id;
        r.payload_len = frame_len[11:0];
        drop_frame();
      end
    end else if (int'(pos) == frame_end + 1) begin
      r.event_res   = (b == run_b) ? EV_ACCEPT : EV_CHK_B_BAD;
      r.msg_id      = frame_id;
      r.payload_len = frame_len[11:0];
      drop_frame();
    end else begin
      drop_frame();
    end
    return r;
  endfunction

  function automatic string show(input logic [2:0] ev, input logic [7:0] d,
                                 input logic [11:0] idx, input logic [7:0] id,
                                 input logic [11:0] len);
    return $sformatf("ev=%0d data=%02h idx=%0d id=%02h len=%0d", ev, d, idx, id, len);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_events.delete();
      drop_frame();
      sync0      = SYNC_BYTE_0_RST;
      sync1      = SYNC_BYTE_1_RST;
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat: got %s", show(out_event_res, out_data_byte,
                     out_payload_index, out_msg_id, out_payload_len));
          mismatches = mismatches + 1;
        end else begin
          want = expected_events.pop_front();
          if (out_event_res !== want.event_res || out_data_byte !== want.data_byte ||
              out_payload_index !== want.payload_index || out_msg_id !== want.msg_id ||
              out_payload_len !== want.payload_len) begin
            if (mismatches < 10)
              $display("result mismatch: expected %s, got %s",
                       show(want.event_res, want.data_byte, want.payload_index,
                            want.msg_id, want.payload_len),
                       show(out_event_res, out_data_byte, out_payload_index,
                            out_msg_id, out_payload_len));
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && in_ready)
        expected_events.insert(expected_events.size(), parse_byte(in_rx_byte));
      if (cfg_we) begin
        if (cfg_index == REG_SYNC_BYTE_0)
          sync0 = cfg_wdata;
        else if (cfg_index == REG_SYNC_BYTE_1)
          sync1 = cfg_wdata;
      end
    end
    events_pending <= expected_events.size();
  end

endmodule

@@ tb/tb_checksummed_frame_parser_top.sv @@
`timescale 1ns / 1ps

module tb_checksummed_frame_parser_top;
  import cfp_pkg::*;

  localparam int FRAME_BYTES = 4096;
  localparam int PAYLOAD_MAX = FRAME_BYTES - HEADER_BYTES - CHECK_BYTES;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum int {
    FLAW_NONE,
    FLAW_CHK_A,
    FLAW_CHK_B,
    FLAW_LEN,
    FLAW_CUT
  } flaw_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_rx_byte;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            out_event_res;
  logic [7:0]            out_data_byte;
  logic [11:0]           out_payload_index;
  logic [7:0]            out_msg_id;
  logic [11:0]           out_payload_len;

  int         mismatches;
  int         events_pending;
  int         send_idle  = 0;
  int         recv_stall = 0;
  int         bytes_sent = 0;
  int         cycles     = 0;
  int         hold_left  = 0;
  logic       hold_go    = 1'b0;
  logic [7:0] cur_sync0;
  logic [7:0] cur_sync1;
  logic [7:0] tx_a;
  logic [7:0] tx_b;

  checksummed_frame_parser_top #(
    .FRAME_BUFFER_BYTES(FRAME_BYTES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_data_byte     (out_data_byte),
    .out_payload_index (out_payload_index),
    .out_msg_id        (out_msg_id),
    .out_payload_len   (out_payload_len)
  );

  frame_event_checker #(
    .FRAME_BUFFER_BYTES(FRAME_BYTES)
  ) checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_data_byte     (out_data_byte),
    .out_payload_index (out_payload_index),
    .out_msg_id        (out_msg_id),
    .out_payload_len   (out_payload_len),
    .mismatches        (mismatches),
    .events_pending    (events_pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_checksummed_frame_parser_top failed");
      $finish;
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      hold_go   <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic emit(input logic [7:0] b);
    tx_a = tx_a + b;
    tx_b = tx_b + tx_a;
    send_byte(b);
  endtask

  task automatic send_frame(input int len, input flaw_t flaw);
    logic [15:0] wire_len;
    int          keep;
    wire_len = 16'(len);
    tx_a     = '0;
    tx_b     = '0;
    emit(cur_sync0);
    emit(cur_sync1);
    emit(8'($urandom));
    emit(wire_len[7:0]);
    emit(wire_len[15:8]);
    if (flaw == FLAW_LEN)
      return;
    keep = (flaw == FLAW_CUT) ? $urandom_range(0, len) : len;
    repeat (keep) emit(8'($urandom));
    if (flaw == FLAW_CUT)
      return;
    send_byte((flaw == FLAW_CHK_A) ? tx_a ^ 8'($urandom_range(1, 255)) : tx_a);
    if (flaw == FLAW_CHK_A)
      return;
    send_byte((flaw == FLAW_CHK_B) ? tx_b ^ 8'($urandom_range(1, 255)) : tx_b);
  endtask

  task automatic run_traffic(input int n);
    int stop;
    int pick;
    int len;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
      if (pick < 60)
        send_frame(len, FLAW_NONE);
      else if (pick < 68)
        send_frame(len, FLAW_CHK_A);
      else if (pick < 76)
        send_frame(len, FLAW_CHK_B);
      else if (pick < 84)
        send_frame($urandom_range(PAYLOAD_MAX + 1, 16'hFFFF), FLAW_LEN);
      else if (pick < 92)
        send_frame(len, FLAW_CUT);
      else
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (events_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic set_sync(input logic [7:0] s0, input logic [7:0] s1, input logic spare);
    settle();
    cfg_write(REG_SYNC_BYTE_0, s0);
    cfg_write(REG_SYNC_BYTE_1, s1);
    if (spare) begin
      cfg_write(REG_SPARE_2, ~s0);
      cfg_write(REG_SPARE_3, 8'h5A);
    end
    cfg_we    <= 1'b0;
    cur_sync0 = s0;
    cur_sync1 = s1;
  endtask

  initial begin
    logic [7:0] same_sync;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    cur_sync0  = SYNC_BYTE_0_RST;
    cur_sync1  = SYNC_BYTE_1_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // stray byte while hunting, then a wrong second sync byte inside an empty frame
    send_byte(8'h00);
    tx_a = '0;
    tx_b = '0;
    emit(cur_sync0);
    send_byte(8'hFF);
    emit(cur_sync1);
    emit(8'hFF);
    emit(8'h00);
    emit(8'h00);
    send_byte(tx_a);
    send_byte(tx_b);
    send_frame(PAYLOAD_MAX + 1, FLAW_LEN);
    send_frame(0, FLAW_CHK_A);
    send_frame(0, FLAW_CHK_B);
    run_traffic(200);

    set_sync(8'h00, 8'hFF, 1'b1);
    send_idle = 71;
    run_traffic(200);

    set_sync(8'hFF, 8'h00, 1'b0);
    send_idle  = 0;
    recv_stall = 71;
    run_traffic(200);

    same_sync = 8'($urandom);
    set_sync(same_sync, same_sync, 1'b0);
    send_idle  = 11;
    recv_stall = 11;
    run_traffic(200);

    set_sync(8'($urandom), 8'($urandom), 1'b0);
    send_idle  = 0;
    recv_stall = 0;
    hold_go <= 1'b1;
    run_traffic(80);

    settle();
    if (mismatches == 0 && events_pending == 0)
      $display("tb_checksummed_frame_parser_top passed");
    else
      $display("tb_checksummed_frame_parser_top failed");
    $finish;
  end

endmodule

@@ checksummed_frame_parser_top.f @@
rtl/cfp_pkg.sv
rtl/cfp_core.sv
rtl/cfp_out_buf.sv
rtl/checksummed_frame_parser_top.sv
rtl/cfp_checker.sv
tb/frame_event_checker.sv
tb/tb_checksummed_frame_parser_top.sv
